### hdl/rse_pkg.sv
`default_nettype none
package rse_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int SYM_W  = 9;

    // field polynomial 0x11b without the x^8 term
    localparam logic [BYTE_W-1:0] FIELD_LOW = 8'h1b;
    localparam logic [SYM_W-1:0]  SYM_MAX   = 9'd511;
    localparam logic [SYM_W-1:0]  BLOCK_MAX = 9'd255;

    typedef enum logic [2:0] {
        M_HOLD,
        M_ENCODE,
        M_DRAIN,
        M_CLEAR,
        M_GEN_INIT,
        M_GEN_STEP
    } t_mode;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_STEP,
        ST_READY
    } t_build_state;

    typedef struct packed {
        t_mode             mode;
        logic [BYTE_W-1:0] fb;
        logic [BYTE_W-1:0] root;
        logic [CNT_W-1:0]  n;
    } t_cell_ctl;

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = x[BYTE_W-1] ? ({x[BYTE_W-2:0], 1'b0} ^ FIELD_LOW) : {x[BYTE_W-2:0], 1'b0};
        end
        return acc;
    endfunction

    // multiply by the primitive element 3
    function automatic logic [BYTE_W-1:0] gf_mul3(input logic [BYTE_W-1:0] a);
        logic [BYTE_W-1:0] x2;
        x2 = a[BYTE_W-1] ? ({a[BYTE_W-2:0], 1'b0} ^ FIELD_LOW) : {a[BYTE_W-2:0], 1'b0};
        return x2 ^ a;
    endfunction

endpackage
`default_nettype wire

### hdl/rse_cell.sv
`default_nettype none
module rse_cell #(
    parameter int IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rse_pkg::t_cell_ctl        i_ctl,
    input  wire logic [rse_pkg::BYTE_W-1:0] i_p_next,
    input  wire logic [rse_pkg::BYTE_W-1:0] i_c_prev,
    output logic      [rse_pkg::BYTE_W-1:0] o_p,
    output logic      [rse_pkg::BYTE_W-1:0] o_c
);
    import rse_pkg::*;

    logic [BYTE_W-1:0] r_p, n_p;
    logic [BYTE_W-1:0] r_c, n_c;
    logic              in_use;
    logic              tail_in_use;

    // this cell and its right neighbor are inside the active generator degree
    assign in_use      = CNT_W'(IDX) < i_ctl.n;
    assign tail_in_use = CNT_W'(IDX + 1) < i_ctl.n;

    always_comb begin
        n_p = r_p;
        n_c = r_c;
        unique case (i_ctl.mode)
            M_HOLD: begin
            end
            M_ENCODE: begin
                if (in_use) begin
                    n_p = (tail_in_use ? i_p_next : '0) ^ gf_mul(r_c, i_ctl.fb);
                end
            end
            M_DRAIN: begin
                n_p = tail_in_use ? i_p_next : '0;
            end
            M_CLEAR: begin
                n_p = '0;
            end
            M_GEN_INIT: begin
                n_c = '0;
            end
            M_GEN_STEP: begin
                n_c = r_c ^ gf_mul(i_c_prev, i_ctl.root);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_c <= '0;
        end else begin
            r_p <= n_p;
            r_c <= n_c;
        end
    end

    assign o_p = r_p;
    assign o_c = r_c;

endmodule
`default_nettype wire

### hdl/reed_solomon_encoder_core.sv
// Systematic Reed-Solomon encoder over GF(2^8), field polynomial 0x11b.
// Input channel (i_valid / o_ready): one message byte per item, i_last on
// the final byte. Output channel (o_valid / i_ready): the message bytes are
// echoed in the cycle after acceptance, then the parity bytes follow, highest
// degree first, with o_is_parity set and o_last_res on the final byte.
// Throughput: one message byte per cycle while the receiver takes them; the
// parity is drained out of the cell chain one byte per cycle, and no new
// byte is taken meanwhile.
// Configuration (i_cfg_valid / o_cfg_ready): one write sets the parity count.
// A write waits until the parity of the last message has left the chain,
// and no byte is taken while a write is offered.
// The generator coefficients are then rebuilt in the cell chain, one root
// per cycle, so o_ready stays low until ST_INIT and ST_STEP have run.
// Reset loads a parity count of 16 and runs the same build.
// A stalled receiver holds the output register; o_ready follows i_ready
// combinationally so nothing is lost or repeated.
// o_length_error rises once a message exceeds 255 - n bytes and stays set
// through its parity bytes.
`default_nettype none
module reed_solomon_encoder_core #(
    parameter int MAX_PARITY = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [rse_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [rse_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_last,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [rse_pkg::BYTE_W-1:0] o_code_byte,
    output logic                            o_is_parity,
    output logic                            o_last_res,
    output logic                            o_length_error
);
    import rse_pkg::*;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_PARITY);

    logic [CNT_W-1:0]  r_cfg;
    logic [CNT_W-1:0]  n_eff;
    t_build_state      r_state, n_state;
    logic [CNT_W-1:0]  r_step, n_step;
    logic [BYTE_W-1:0] r_root, n_root;

    logic [SYM_W-1:0]  r_cnt;
    logic [SYM_W-1:0]  cnt_inc;
    logic              r_tl;
    logic              tl_inc;

    logic              r_emit;
    logic [CNT_W-1:0]  r_left;
    logic              r_emit_err;

    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_op;
    logic              r_ol;
    logic              r_oe;

    logic              out_free;
    logic              in_acc;
    logic              emit_go;
    logic              cfg_acc;

    t_cell_ctl         ctl;
    logic [BYTE_W-1:0] p_chain [MAX_PARITY+1];
    logic [BYTE_W-1:0] c_chain [MAX_PARITY+1];

    assign n_eff = (r_cfg > MAX_N) ? MAX_N : r_cfg;

    assign out_free    = !r_ov || i_ready;
    assign o_ready     = (r_state == ST_READY) && !r_emit && out_free && !i_cfg_valid;
    assign o_cfg_ready = !r_emit;
    assign in_acc      = i_valid && o_ready;
    assign emit_go     = r_emit && out_free;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign cnt_inc = (r_cnt < SYM_MAX) ? r_cnt + 9'd1 : r_cnt;
    assign tl_inc  = r_tl || (cnt_inc > (BLOCK_MAX - SYM_W'(n_eff)));

    // generator build sequencer and cell mode select
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_root   = r_root;
        ctl.mode = M_HOLD;
        ctl.fb   = i_data_byte ^ p_chain[0];
        ctl.root = gf_mul3(r_root);
        ctl.n    = n_eff;
        unique case (r_state)
            ST_INIT: begin
                ctl.mode = M_GEN_INIT;
                n_step   = '0;
                n_root   = 8'h01;
                n_state  = ST_STEP;
            end
            ST_STEP: begin
                if (r_step == n_eff) begin
                    n_state = ST_READY;
                end else begin
                    ctl.mode = M_GEN_STEP;
                    n_root   = gf_mul3(r_root);
                    n_step   = r_step + 6'd1;
                end
            end
            ST_READY: begin
                priority if (in_acc) begin
                    ctl.mode = (i_last && n_eff == '0) ? M_CLEAR : M_ENCODE;
                    if (i_last && n_eff == '0) begin
                        ctl.mode = M_CLEAR;
                    end
                end else if (emit_go) begin
                    ctl.mode = M_DRAIN;
                end else begin
                    ctl.mode = M_HOLD;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
        if (cfg_acc) begin
            n_state = ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cfg   <= 6'd16;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_root <= n_root;
    end

    // message, drain and output valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_tl       <= 1'b0;
            r_emit     <= 1'b0;
            r_left     <= '0;
            r_emit_err <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_last) begin
                    r_cnt      <= '0;
                    r_tl       <= 1'b0;
                    r_emit     <= n_eff != '0;
                    r_left     <= n_eff;
                    r_emit_err <= tl_inc;
                end else begin
                    r_cnt <= cnt_inc;
                    r_tl  <= tl_inc;
                end
            end else if (emit_go) begin
                r_left <= r_left - 6'd1;
                if (r_left == 6'd1) begin
                    r_emit <= 1'b0;
                end
            end
            if (in_acc || emit_go) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ob <= i_data_byte;
            r_op <= 1'b0;
            r_ol <= i_last && (n_eff == '0);
            r_oe <= tl_inc;
        end else if (emit_go) begin
            r_ob <= p_chain[0];
            r_op <= 1'b1;
            r_ol <= r_left == 6'd1;
            r_oe <= r_emit_err;
        end
    end

    assign o_valid        = r_ov;
    assign o_code_byte    = r_ob;
    assign o_is_parity    = r_op;
    assign o_last_res     = r_ol;
    assign o_length_error = r_oe;

    // cell chain: parity flows toward cell 0, coefficients toward the tail
    assign p_chain[MAX_PARITY] = '0;
    assign c_chain[0]          = 8'h01;

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        rse_cell #(
            .IDX (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_p_next (p_chain[j+1]),
            .i_c_prev (c_chain[j]),
            .o_p      (p_chain[j]),
            .o_c      (c_chain[j+1])
        );
    end

endmodule
`default_nettype wire
